>>> rtl/hrd_pkg.sv
// ----------------------------------------------------------------------------
// hrd_pkg
// Types and constants shared by the HTTP response deframer.
// ----------------------------------------------------------------------------
package hrd_pkg;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_PREFIX  = 4'd1,
		PH_SEEK    = 4'd2,
		PH_SWS     = 4'd3,
		PH_SDIG    = 4'd4,
		PH_HDR     = 4'd5,
		PH_PLAIN   = 4'd6,
		PH_CSTART  = 4'd7,
		PH_CDIG    = 4'd8,
		PH_CEXT    = 4'd9,
		PH_CDATA   = 4'd10,
		PH_TRAIL   = 4'd11,
		PH_SWALLOW = 4'd12,
		PH_DRAIN   = 4'd13
	} phase_t;

	localparam logic [1:0] KIND_BODY   = 2'd0;
	localparam logic [1:0] KIND_FINISH = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [1:0] ERR_MALFORMED = 2'd0;
	localparam logic [1:0] ERR_STATUS    = 2'd1;
	localparam logic [1:0] ERR_NONOK     = 2'd2;
	localparam logic [1:0] ERR_EMPTY     = 2'd3;

	// key matcher codes (below the key length = position in key)
	localparam logic [4:0] KM_WS   = 5'd16;
	localparam logic [4:0] KM_DIG  = 5'd17;
	localparam logic [4:0] KM_SCAN = 5'd18;
	localparam logic [4:0] KM_DONE = 5'd30;
	localparam logic [4:0] KM_DEAD = 5'd31;

	localparam logic [9:0] STATUS_MAX = 10'd999;
	localparam logic [9:0] STATUS_LO  = 10'd200;
	localparam logic [9:0] STATUS_HI  = 10'd299;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] body_byte;
		logic [9:0] status_code;
		logic [1:0] error_code;
		logic [23:0] body_length;
		logic       last;
	} result_t;

	function automatic logic [7:0] len_key_char(input logic [4:0] i);
		logic [7:0] c;
		case (i)
			5'd0: c = "c";  5'd1: c = "o";  5'd2: c = "n";  5'd3: c = "t";
			5'd4: c = "e";  5'd5: c = "n";  5'd6: c = "t";  5'd7: c = "-";
			5'd8: c = "l";  5'd9: c = "e";  5'd10: c = "n"; 5'd11: c = "g";
			5'd12: c = "t"; 5'd13: c = "h"; 5'd14: c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] enc_key_char(input logic [4:0] i);
		logic [7:0] c;
		case (i)
			5'd0: c = "t";  5'd1: c = "r";  5'd2: c = "a";  5'd3: c = "n";
			5'd4: c = "s";  5'd5: c = "f";  5'd6: c = "e";  5'd7: c = "r";
			5'd8: c = "-";  5'd9: c = "e";  5'd10: c = "n"; 5'd11: c = "c";
			5'd12: c = "o"; 5'd13: c = "d"; 5'd14: c = "i"; 5'd15: c = "n";
			5'd16: c = "g"; 5'd17: c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] word_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = "c"; 3'd1: c = "h"; 3'd2: c = "u"; 3'd3: c = "n";
			3'd4: c = "k"; 3'd5: c = "e"; 3'd6: c = "d";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = "H"; 3'd1: c = "T"; 3'd2: c = "T"; 3'd3: c = "P"; 3'd4: c = "/";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	// value 16 means not a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [4:0] v;
		if (b >= "0" && b <= "9") v = 5'(b - "0");
		else if (b >= "a" && b <= "f") v = 5'(b - "a" + 8'd10);
		else if (b >= "A" && b <= "F") v = 5'(b - "A" + 8'd10);
		else v = 5'd16;
		return v;
	endfunction

endpackage

>>> rtl/hrd_if.sv
// ----------------------------------------------------------------------------
// hrd_if
// Valid/ready channel interfaces for the deframer.
// ----------------------------------------------------------------------------
interface hrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_end;
	modport source (output valid, data_byte, stream_end, input ready);
	modport sink (input valid, data_byte, stream_end, output ready);
endinterface

interface hrd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  body_byte;
	logic [9:0]  status_code;
	logic [1:0]  error_code;
	logic [23:0] body_length;
	logic        last;
	modport source (output valid, kind, body_byte, status_code, error_code,
		body_length, last, input ready);
	modport sink (input valid, kind, body_byte, status_code, error_code,
		body_length, last, output ready);
endinterface

interface hrd_cfg_if;
	logic valid;
	logic ready;
	logic accept_only_success;
	modport source (output valid, accept_only_success, input ready);
	modport sink (input valid, accept_only_success, output ready);
endinterface

>>> rtl/hrd_core.sv
// ----------------------------------------------------------------------------
// hrd_core
// Per-byte parser state update: prefix, status, header keys, body, chunks.
// ----------------------------------------------------------------------------
module hrd_core #(
	parameter int unsigned MAX_BYTES = 8388608
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           b,
	input  logic                 se,
	input  logic                 only_ok,
	output logic [1:0]           n_res,
	output hrd_pkg::result_t     res0,
	output hrd_pkg::result_t     res1
);
	localparam logic [24:0] CAPW = 25'(MAX_BYTES);

	hrd_pkg::phase_t phase_q, ph;
	logic [24:0] byte_count_q, bc;
	logic [9:0]  status_q, st;
	logic [2:0]  prefix_q, pm;
	logic [31:0] tail_q;
	logic        line_start_q, ls;
	logic [4:0]  lkm_q, lkm, ckm_q, ckm;
	logic [2:0]  cwm_q, cwm;
	logic [24:0] decl_q, decl;
	logic        known_q, known;
	logic        chunked_q, chunked;
	logic [23:0] crem_q, crem;
	logic [23:0] body_q, bodyc;

	logic [7:0] p1, p2, p3, p4, c;
	logic       fin, hdr_end;
	logic [2:0] verdict;
	logic [4:0] hv;
	logic [13:0] dec10;
	logic [28:0] dsum;
	logic [28:0] hsum;
	logic [25:0] asum;

	function automatic hrd_pkg::result_t mk(input logic [1:0] k, input logic [7:0] by,
		input logic [9:0] s, input logic [1:0] e, input logic [23:0] bl);
		hrd_pkg::result_t r;
		r.kind = k;
		r.body_byte = by;
		r.status_code = s;
		r.error_code = e;
		r.body_length = bl;
		r.last = (k != hrd_pkg::KIND_BODY);
		return r;
	endfunction

	always_comb begin
		ph = phase_q; bc = byte_count_q; st = status_q; pm = prefix_q;
		ls = line_start_q; lkm = lkm_q; ckm = ckm_q; cwm = cwm_q; decl = decl_q;
		known = known_q; chunked = chunked_q; crem = crem_q; bodyc = body_q;
		p1 = tail_q[7:0]; p2 = tail_q[15:8]; p3 = tail_q[23:16]; p4 = tail_q[31:24];
		c = b | 8'h20;
		fin = 1'b0; hdr_end = 1'b0;
		n_res = 2'd0;
		res0 = mk(hrd_pkg::KIND_BODY, 8'd0, 10'd0, 2'd0, 24'd0);
		res1 = res0;
		verdict = 3'd4; hv = 5'd0; dec10 = 14'd0; dsum = 29'd0; hsum = 29'd0; asum = 26'd0;

		if (se) begin
			if (phase_q != hrd_pkg::PH_DRAIN) begin
				n_res = 2'd1;
				if (phase_q == hrd_pkg::PH_IDLE)
					res0 = mk(hrd_pkg::KIND_ERROR, 8'd0, status_q, hrd_pkg::ERR_EMPTY, body_q);
				else if (phase_q == hrd_pkg::PH_PREFIX || byte_count_q < 25'd12)
					res0 = mk(hrd_pkg::KIND_ERROR, 8'd0, status_q, hrd_pkg::ERR_MALFORMED,
						body_q);
				else if (phase_q <= hrd_pkg::PH_HDR && status_q == 10'd0)
					res0 = mk(hrd_pkg::KIND_ERROR, 8'd0, status_q, hrd_pkg::ERR_STATUS, body_q);
				else if (phase_q <= hrd_pkg::PH_HDR && only_ok &&
						(status_q < hrd_pkg::STATUS_LO || status_q > hrd_pkg::STATUS_HI))
					res0 = mk(hrd_pkg::KIND_ERROR, 8'd0, status_q, hrd_pkg::ERR_NONOK, body_q);
				else
					res0 = mk(hrd_pkg::KIND_FINISH, 8'd0, status_q, 2'd0, body_q);
			end
			ph = hrd_pkg::PH_IDLE; bc = '0; st = '0; pm = '0; ls = 1'b1; lkm = '0;
			ckm = '0; cwm = '0; decl = '0; known = 1'b0; chunked = 1'b0; crem = '0;
			bodyc = '0;
		end else if (phase_q != hrd_pkg::PH_DRAIN) begin
			if (ph == hrd_pkg::PH_IDLE) ph = hrd_pkg::PH_PREFIX;
			bc = byte_count_q + 25'd1;
			if (ph <= hrd_pkg::PH_HDR) begin
				// header key matchers
				if (lkm != hrd_pkg::KM_DONE) begin
					if (line_start_q && lkm == hrd_pkg::KM_DEAD) lkm = 5'd0;
					if (lkm < 5'd15) begin
						if (c == hrd_pkg::len_key_char(lkm)) begin
							lkm = lkm + 5'd1;
							if (lkm == 5'd15) lkm = hrd_pkg::KM_WS;
						end else lkm = hrd_pkg::KM_DEAD;
					end else if (lkm == hrd_pkg::KM_WS) begin
						if (b == 8'h20 || b == 8'h09) begin
						end else if (hrd_pkg::is_digit(b)) begin
							decl = 25'(b - "0");
							lkm = hrd_pkg::KM_DIG;
						end else lkm = hrd_pkg::KM_DONE;
					end else if (lkm == hrd_pkg::KM_DIG) begin
						if (hrd_pkg::is_digit(b)) begin
							dsum = 29'({decl_q, 3'b000}) + 29'({decl_q, 1'b0}) + 29'(b - "0");
							decl = (dsum > 29'(CAPW)) ? CAPW : 25'(dsum);
						end else begin
							lkm = hrd_pkg::KM_DONE;
							known = 1'b1;
						end
					end
				end
				if (ckm != hrd_pkg::KM_DONE) begin
					if (line_start_q && ckm == hrd_pkg::KM_DEAD) ckm = 5'd0;
					if (ckm < 5'd18) begin
						if (c == hrd_pkg::enc_key_char(ckm)) begin
							ckm = ckm + 5'd1;
							if (ckm == 5'd18) begin
								ckm = hrd_pkg::KM_SCAN;
								cwm = 3'd0;
							end
						end else ckm = hrd_pkg::KM_DEAD;
					end else if (ckm == hrd_pkg::KM_SCAN) begin
						if (b == 8'h0A) ckm = hrd_pkg::KM_DONE;
						else begin
							if (cwm < 3'd7 && c == hrd_pkg::word_char(cwm)) cwm = cwm + 3'd1;
							else cwm = (c == "c") ? 3'd1 : 3'd0;
							if (cwm == 3'd7) begin
								chunked = 1'b1;
								ckm = hrd_pkg::KM_DONE;
							end
						end
					end
				end
				ls = (b == 8'h0A);

				case (ph)
					hrd_pkg::PH_PREFIX: begin
						if (b == hrd_pkg::prefix_char(pm)) begin
							pm = pm + 3'd1;
							if (pm == 3'd5) ph = hrd_pkg::PH_SEEK;
						end else begin
							n_res = 2'd1;
							res0 = mk(hrd_pkg::KIND_ERROR, 8'd0, st, hrd_pkg::ERR_MALFORMED,
								bodyc);
							fin = 1'b1;
						end
					end
					hrd_pkg::PH_SEEK: if (b == 8'h20) ph = hrd_pkg::PH_SWS;
					hrd_pkg::PH_SWS: begin
						if (b == 8'h20 || b == 8'h09) begin
						end else if (hrd_pkg::is_digit(b)) begin
							st = 10'(b - "0");
							ph = hrd_pkg::PH_SDIG;
						end else ph = hrd_pkg::PH_HDR;
					end
					hrd_pkg::PH_SDIG: begin
						if (hrd_pkg::is_digit(b)) begin
							dec10 = 14'({status_q, 3'b000}) + 14'({status_q, 1'b0}) + 14'(b - "0");
							st = (dec10 > 14'(hrd_pkg::STATUS_MAX)) ? hrd_pkg::STATUS_MAX
								: 10'(dec10);
						end else ph = hrd_pkg::PH_HDR;
					end
					default: ;
				endcase

				hdr_end = !fin && ph != hrd_pkg::PH_PREFIX && b == 8'h0A &&
					(p1 == 8'h0A || (p1 == 8'h0D && p2 == 8'h0A && p3 == 8'h0D));
				if (hdr_end) begin
					if (st == 10'd0) verdict = 3'(hrd_pkg::ERR_STATUS);
					else if (only_ok && (st < hrd_pkg::STATUS_LO || st > hrd_pkg::STATUS_HI))
						verdict = 3'(hrd_pkg::ERR_NONOK);
					if (verdict < 3'd4) begin
						n_res = 2'd1;
						res0 = mk(hrd_pkg::KIND_ERROR, 8'd0, st, 2'(verdict), bodyc);
						fin = 1'b1;
					end else begin
						if (known) begin
							asum = 26'(bc) + 26'(decl);
							decl = (asum > 26'(CAPW)) ? CAPW : 25'(asum);
						end
						if (known && decl <= bc) begin
							n_res = 2'd1;
							res0 = mk(hrd_pkg::KIND_FINISH, 8'd0, st, 2'd0, bodyc);
							fin = 1'b1;
						end else ph = chunked ? hrd_pkg::PH_CSTART : hrd_pkg::PH_PLAIN;
					end
				end
			end else begin
				hv = hrd_pkg::hex_val(b);
				case (ph)
					hrd_pkg::PH_PLAIN: begin
						bodyc = body_q + 24'd1;
						n_res = 2'd1;
						res0 = mk(hrd_pkg::KIND_BODY, b, st, 2'd0, bodyc);
					end
					hrd_pkg::PH_CSTART: begin
						if (hv < 5'd16) begin
							crem = 24'(hv);
							ph = hrd_pkg::PH_CDIG;
						end else if (!(b == 8'h20 || (b >= 8'd9 && b <= 8'd13)))
							ph = hrd_pkg::PH_SWALLOW;
					end
					hrd_pkg::PH_CDIG, hrd_pkg::PH_CEXT: begin
						if (ph == hrd_pkg::PH_CDIG && hv < 5'd16) begin
							hsum = {crem_q, 4'h0} + 29'(hv[3:0]);
							crem = (hsum > 29'hFFFFFF) ? 24'hFFFFFF : 24'(hsum);
						end else if (b == 8'h0A)
							ph = (crem_q == 24'd0) ? hrd_pkg::PH_TRAIL : hrd_pkg::PH_CDATA;
						else ph = hrd_pkg::PH_CEXT;
					end
					hrd_pkg::PH_CDATA: begin
						bodyc = body_q + 24'd1;
						n_res = 2'd1;
						res0 = mk(hrd_pkg::KIND_BODY, b, st, 2'd0, bodyc);
						if (crem_q > 24'd0) crem = crem_q - 24'd1;
						if (crem == 24'd0) ph = hrd_pkg::PH_CSTART;
					end
					hrd_pkg::PH_TRAIL: begin
						if (b == 8'h0A && (p1 == 8'h0A || (p1 == 8'h0D && p2 == 8'h0A))) begin
							n_res = 2'd1;
							res0 = mk(hrd_pkg::KIND_FINISH, 8'd0, st, 2'd0, bodyc);
							fin = 1'b1;
						end
					end
					hrd_pkg::PH_SWALLOW: begin
						if (b == 8'h0A && p1 == 8'h0D && p2 == 8'h0A && p3 == 8'h0D && p4 == "0")
						begin
							n_res = 2'd1;
							res0 = mk(hrd_pkg::KIND_FINISH, 8'd0, st, 2'd0, bodyc);
							fin = 1'b1;
						end
					end
					default: ;
				endcase
				if (!fin && known && bc >= decl) begin
					if (n_res == 2'd0) res0 = mk(hrd_pkg::KIND_FINISH, 8'd0, st, 2'd0, bodyc);
					else res1 = mk(hrd_pkg::KIND_FINISH, 8'd0, st, 2'd0, bodyc);
					n_res = n_res + 2'd1;
					fin = 1'b1;
				end
			end

			// byte cap: ends as at stream end (phase already advanced)
			if (!fin && bc >= CAPW) begin
				if (ph == hrd_pkg::PH_PREFIX || bc < 25'd12)
					res1 = mk(hrd_pkg::KIND_ERROR, 8'd0, st, hrd_pkg::ERR_MALFORMED, bodyc);
				else if (ph <= hrd_pkg::PH_HDR && st == 10'd0)
					res1 = mk(hrd_pkg::KIND_ERROR, 8'd0, st, hrd_pkg::ERR_STATUS, bodyc);
				else if (ph <= hrd_pkg::PH_HDR && only_ok &&
						(st < hrd_pkg::STATUS_LO || st > hrd_pkg::STATUS_HI))
					res1 = mk(hrd_pkg::KIND_ERROR, 8'd0, st, hrd_pkg::ERR_NONOK, bodyc);
				else
					res1 = mk(hrd_pkg::KIND_FINISH, 8'd0, st, 2'd0, bodyc);
				if (n_res == 2'd0) res0 = res1;
				n_res = n_res + 2'd1;
				fin = 1'b1;
			end
			if (fin) ph = hrd_pkg::PH_DRAIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrd_pkg::PH_IDLE;
			byte_count_q <= '0; status_q <= '0; prefix_q <= '0; tail_q <= '0;
			line_start_q <= 1'b1; lkm_q <= '0; ckm_q <= '0; cwm_q <= '0;
			decl_q <= '0; known_q <= 1'b0; chunked_q <= 1'b0; crem_q <= '0; body_q <= '0;
		end else if (step) begin
			phase_q <= ph; byte_count_q <= bc; status_q <= st; prefix_q <= pm;
			tail_q <= se ? 32'd0 : (phase_q == hrd_pkg::PH_DRAIN ? tail_q : {tail_q[23:0], b});
			line_start_q <= ls; lkm_q <= lkm; ckm_q <= ckm; cwm_q <= cwm;
			decl_q <= decl; known_q <= known; chunked_q <= chunked; crem_q <= crem;
			body_q <= bodyc;
		end
	end
endmodule

>>> rtl/hrd_out_buf.sv
// ----------------------------------------------------------------------------
// hrd_out_buf
// Result queue: up to two results per request, drained one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module hrd_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [1:0]       n_res,
	input  hrd_pkg::result_t res0,
	input  hrd_pkg::result_t res1,
	output logic             space,
	hrd_out_if.source        o
);
	hrd_pkg::result_t mem_q [4];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic pop;

	assign pop = o.valid && o.ready;
	assign o.valid = (cnt_q != 3'd0);
	assign o.kind = mem_q[rd_q].kind;
	assign o.body_byte = mem_q[rd_q].body_byte;
	assign o.status_code = mem_q[rd_q].status_code;
	assign o.error_code = mem_q[rd_q].error_code;
	assign o.body_length = mem_q[rd_q].body_length;
	assign o.last = mem_q[rd_q].last;
	// room for a worst-case request of two results
	assign space = (cnt_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push && n_res != 2'd0) mem_q[wr_q] <= res0;
		if (push && n_res == 2'd2) mem_q[wr_q + 2'd1] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			if (pop) rd_q <= rd_q + 2'd1;
			if (push) wr_q <= wr_q + n_res;
			cnt_q <= cnt_q + (push ? 3'(n_res) : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end
endmodule

>>> rtl/http_response_deframer.sv
// ----------------------------------------------------------------------------
// http_response_deframer
// HTTP/1.x response parser with content-length and chunked body decoding.
// ----------------------------------------------------------------------------
// Results: the core is combinational; a byte's results are registered into the result queue when it is accepted.
// Throughput: one byte per cycle; input stalls only while three or more
// results wait in the four-entry result queue (output backpressure).
// Reset (arst_n low): parser idle, config cleared, result queue empty.
module http_response_deframer #(
	parameter int unsigned MAX_BYTES = 8388608
) (
	input logic       clk,
	input logic       arst_n,
	hrd_in_if.sink    in_ch,
	hrd_out_if.source out_ch,
	hrd_cfg_if.sink   cfg
);
	logic only_ok_q;
	logic space, step;
	logic [1:0] n_res;
	hrd_pkg::result_t res0, res1;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = space;
	assign step = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) only_ok_q <= 1'b0;
		else if (cfg.valid) only_ok_q <= cfg.accept_only_success;
	end

	hrd_core #(.MAX_BYTES(MAX_BYTES)) u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .b(in_ch.data_byte),
		.se(in_ch.stream_end), .only_ok(only_ok_q), .n_res(n_res), .res0(res0), .res1(res1)
	);

	hrd_out_buf u_buf (
		.clk(clk), .arst_n(arst_n), .push(step), .n_res(n_res), .res0(res0), .res1(res1),
		.space(space), .o(out_ch)
	);
endmodule

>>> rtl/hrd_checker.sv
// ----------------------------------------------------------------------------
// hrd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module hrd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [1:0] error_code,
	input logic [7:0] body_byte,
	input logic       last
);
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind != hrd_pkg::KIND_BODY))) else $error("last mismatch");
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind != 2'd3)) else $error("bad kind");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != hrd_pkg::KIND_ERROR) |-> (error_code == 2'd0))
		else $error("error code on non-error");
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != hrd_pkg::KIND_BODY) |-> (body_byte == 8'd0))
		else $error("byte on final result");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("valid dropped");
endmodule

bind http_response_deframer hrd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.kind(out_ch.kind), .error_code(out_ch.error_code), .body_byte(out_ch.body_byte),
	.last(out_ch.last)
);
